[src/sfr_pkg.sv]
// ============================================================================
// Stream find-and-replace package
// Shared constants, register codes and controller/datapath interface types.
// ============================================================================
package sfr_pkg;

    // Default sizes of the pattern window and of the replacement text.
    localparam int MAX_PATTERN_DEF     = 8;
    localparam int MAX_REPLACEMENT_DEF = 8;

    // Newline byte: it closes a line and releases the window.
    localparam logic [7:0] NEWLINE = 8'h0A;

    // Register indexes on the configuration port (byte address = 8 * index).
    typedef enum logic [1:0] {
        REG_PLEN = 2'd0,
        REG_PAT  = 2'd1,
        REG_RLEN = 2'd2,
        REG_REP  = 2'd3
    } reg_idx_t;

    // Bit positions inside m_tuser.
    localparam int TU_VALID = 0;
    localparam int TU_DONE  = 1;

    // Source of an emitted result byte.
    typedef enum logic [1:0] {
        SEL_WIN   = 2'd0,
        SEL_REP   = 2'd1,
        SEL_NL    = 2'd2,
        SEL_EMPTY = 2'd3
    } out_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     append;      // push the accepted byte into the window
        logic     shift;       // drop the oldest window byte
        logic     clear_win;   // a match was found: empty the window
        logic     close_line;  // the current line is closed
        logic     emit;        // load a result into the output register
        out_sel_t sel;         // where the result byte comes from
        logic     last;        // last result of this request
        logic     done;        // final result of an end-of-text request
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;
        logic count_one;
        logic win_prefix;      // window is a prefix of the pattern
        logic win_full;        // window equals the whole pattern
        logic shift_prefix;    // window without its oldest byte is a prefix
        logic rep_zero;        // replacement is empty
        logic rep_last;        // replacement index is at its last byte
        logic line_open;
        logic out_free;        // output register can take a result
    } stat_t;

endpackage

[src/stream_find_replace_top.sv]
// ============================================================================
// Stream find-and-replace top level
// Byte-stream search and replace with an APB register port.
// ============================================================================
// Text enters on the s_ stream one byte per request: s_tdata is the byte and
// s_tuser[0] marks an end-of-text request, whose byte is ignored. Every
// leftmost, non-overlapping occurrence of the configured pattern is replaced
// by the replacement text, which is never scanned again. Bytes that could
// still begin a match wait in a window of up to MAX_PATTERN bytes. A newline
// releases the window, and end of text releases it and closes an
// unterminated last line with a newline, or gives an empty marker.
// Results leave on the m_ stream, one byte a request: m_tdata is the byte,
// m_tuser[0] says whether it carries a byte, m_tuser[1] marks the final result
// of end of text, and m_tlast marks the last result caused by an input.
// An input request is taken only while the controller is idle, and its
// results are loaded into the output register by the scan, replacement,
// flush and close steps; a match, a request that leaves all its bytes
// pending, or a newline or end of text that meets an empty window also
// takes a step that loads no result. The controller handles one request at
// a time, taking no new input until it is back in idle.
// A stalled receiver holds the result in the output register, and a step
// with a result to load waits until it is taken. Reset empties the window
// and the output register and loads pattern length 1 and all else zero.
// ============================================================================
module stream_find_replace_top #(
    parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
    parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] text_byte
    input  logic [0:0]  s_tuser,    // [0] end_of_text
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tlast,
    output logic [1:0]  m_tuser,    // [0] byte_valid, [1] text_done
    // Register port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import sfr_pkg::*;

    // Configuration registers.
    logic [3:0]  plen_reg;
    logic [63:0] pat_reg;
    logic [3:0]  rlen_reg;
    logic [63:0] rep_reg;

    logic        cfg_wr;
    reg_idx_t    cfg_idx;
    logic        plen_wr;

    cmd_t        cmd;
    stat_t       stat;
    logic        s_nl;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[4:3]);
    assign plen_wr = cfg_wr && (cfg_idx == REG_PLEN);

    // Registers are 64 bits wide at byte addresses eight apart; the low
    // address bits are not decoded.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plen_reg <= 4'd1;
            pat_reg  <= '0;
            rlen_reg <= '0;
            rep_reg  <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_PLEN: plen_reg <= pwdata[3:0];
                REG_PAT:  pat_reg  <= pwdata;
                REG_RLEN: rlen_reg <= pwdata[3:0];
                REG_REP:  rep_reg  <= pwdata;
                default:  ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_PLEN: prdata = {60'd0, plen_reg};
            REG_PAT:  prdata = pat_reg;
            REG_RLEN: prdata = {60'd0, rlen_reg};
            REG_REP:  prdata = rep_reg;
            default:  prdata = '0;
        endcase
    end

    // A newline request releases the window just like end of text, but
    // always ends with a newline of its own.
    assign s_nl = (s_tdata == NEWLINE);

    sfr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_end    (s_tuser[0]),
        .s_nl     (s_nl),
        .stat     (stat),
        .cmd      (cmd)
    );

    sfr_dp #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .cfg_clear (plen_wr),
        .in_byte   (s_tdata),
        .plen_cfg  (plen_reg),
        .pat_cfg   (pat_reg),
        .rlen_cfg  (rlen_reg),
        .rep_cfg   (rep_reg),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .stat      (stat)
    );

    // Registers must only be written by the user while the block is idle, with no
    // input request taken in the same cycle; the block itself does not enforce it.
    a_cfg_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr |-> (s_tready && !s_tvalid))
        else $error("register write during input");

    // Pattern length always reads back within its four bits.
    a_plen_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && !pwrite && (cfg_idx == REG_PLEN)) |-> (prdata[63:4] == '0))
        else $error("pattern length read back with stray bits");

    // A request can only be taken when no result of an earlier one is
    // still being produced by the controller.
    a_take_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> !cmd.emit)
        else $error("request taken while results were being produced");

endmodule

[src/sfr_ctrl.sv]
// ============================================================================
// Stream find-and-replace controller
// Sequences the scan, replacement, flush and line-close steps of one request.
// ============================================================================
module sfr_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic           s_end,
    input  logic           s_nl,
    input  sfr_pkg::stat_t stat,
    output sfr_pkg::cmd_t  cmd
);
    import sfr_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_REPL  = 5'b00100,
        ST_FLUSH = 5'b01000,
        ST_CLOSE = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   end_reg, end_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            end_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            end_reg   <= end_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        end_next   = end_reg;
        cmd        = '0;
        cmd.sel    = SEL_WIN;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    end_next = s_end;
                    if (s_end || s_nl) begin
                        state_next = ST_FLUSH;
                    end else begin
                        cmd.append = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (stat.count_zero) begin
                    state_next = ST_IDLE;
                end else if (stat.win_prefix) begin
                    // Either a full match or a partial one that must wait.
                    if (stat.win_full) begin
                        cmd.clear_win = 1'b1;
                        state_next    = stat.rep_zero ? ST_IDLE : ST_REPL;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else if (stat.out_free) begin
                    // No match can start at the oldest byte: release it.
                    cmd.emit  = 1'b1;
                    cmd.shift = 1'b1;
                    cmd.sel   = SEL_WIN;
                    cmd.last  = stat.count_one || stat.shift_prefix;
                    if (cmd.last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_REPL: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.sel  = SEL_REP;
                    cmd.last = stat.rep_last;
                    if (stat.rep_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                if (stat.count_zero) begin
                    state_next = ST_CLOSE;
                end else if (stat.out_free) begin
                    cmd.emit  = 1'b1;
                    cmd.shift = 1'b1;
                    cmd.sel   = SEL_WIN;
                    cmd.last  = end_reg && stat.count_one && !stat.line_open;
                    cmd.done  = cmd.last;
                    if (cmd.last) begin
                        cmd.close_line = 1'b1;
                        state_next     = ST_IDLE;
                    end else if (stat.count_one) begin
                        state_next = ST_CLOSE;
                    end
                end
            end
            ST_CLOSE: begin
                if (stat.out_free) begin
                    cmd.emit       = 1'b1;
                    cmd.last       = 1'b1;
                    cmd.done       = end_reg;
                    cmd.close_line = 1'b1;
                    cmd.sel        = (!end_reg || stat.line_open) ? SEL_NL : SEL_EMPTY;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The replacement step is only entered with a non-empty replacement.
    a_repl_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REPL) |-> !stat.rep_zero)
        else $error("replacement step entered with empty replacement");

    // A text byte pushed into the window is always scanned next.
    a_append_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.append |=> (state_reg == ST_SCAN))
        else $error("appended byte not followed by a scan");

    // The last result of a request always returns the controller to idle.
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && cmd.last) |=> (state_reg == ST_IDLE))
        else $error("controller busy after last result of a request");

endmodule

[src/sfr_dp.sv]
// ============================================================================
// Stream find-and-replace datapath
// Pending-byte window, pattern compare, replacement index and output register.
// ============================================================================
module sfr_dp #(
    parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
    parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  sfr_pkg::cmd_t  cmd,
    input  logic           cfg_clear,
    input  logic [7:0]     in_byte,
    input  logic [3:0]     plen_cfg,
    input  logic [63:0]    pat_cfg,
    input  logic [3:0]     rlen_cfg,
    input  logic [63:0]    rep_cfg,
    input  logic           m_tready,
    output logic           m_tvalid,
    output logic [7:0]     m_tdata,
    output logic           m_tlast,
    output logic [1:0]     m_tuser,
    output sfr_pkg::stat_t stat
);
    import sfr_pkg::*;

    localparam int CW  = $clog2(MAX_PATTERN + 1);
    localparam int RLW = $clog2(MAX_REPLACEMENT + 1);
    localparam int RIW = (MAX_REPLACEMENT > 1) ? $clog2(MAX_REPLACEMENT) : 1;

    logic [7:0]       win_reg [MAX_PATTERN];
    logic [CW-1:0]    count_reg;
    logic             line_open_reg;
    logic [RIW-1:0]   rep_idx_reg;

    logic             m_valid_reg;
    logic [7:0]       m_data_reg;
    logic             m_last_reg;
    logic [1:0]       m_user_reg;

    logic [CW-1:0]    plen_eff;
    logic [RLW-1:0]   rlen_eff;
    logic [MAX_PATTERN-1:0] match_ok;
    logic [MAX_PATTERN-1:0] shift_ok;
    logic [7:0]       out_byte;

    // Lengths above MAX_PATTERN and MAX_REPLACEMENT are clipped to them.
    assign plen_eff = (plen_cfg > 4'(MAX_PATTERN)) ? CW'(MAX_PATTERN) : CW'(plen_cfg);
    assign rlen_eff = (rlen_cfg > 4'(MAX_REPLACEMENT)) ? RLW'(MAX_REPLACEMENT)
                                                       : RLW'(rlen_cfg);

    // Compare every pending byte with its pattern byte, both in place and
    // one position on, as the window would be after dropping its oldest byte.
    always_comb begin
        match_ok = '1;
        shift_ok = '1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if ((CW'(i) < count_reg) && (win_reg[i] != pat_cfg[8*i +: 8])) begin
                match_ok[i] = 1'b0;
            end
        end
        for (int i = 0; i < MAX_PATTERN - 1; i++) begin
            if (((CW + 1)'(i + 1) < (CW + 1)'(count_reg)) &&
                (win_reg[i + 1] != pat_cfg[8*i +: 8])) begin
                shift_ok[i] = 1'b0;
            end
        end
    end

    always_comb begin
        stat.count_zero   = (count_reg == '0);
        stat.count_one    = (count_reg == CW'(1));
        stat.win_prefix   = (count_reg <= plen_eff) && (&match_ok);
        stat.win_full     = stat.win_prefix && (count_reg == plen_eff);
        stat.shift_prefix = ((CW + 1)'(count_reg) <= (CW + 1)'(plen_eff) + (CW + 1)'(1))
                            && (&shift_ok);
        stat.rep_zero     = (rlen_eff == '0);
        stat.rep_last     = ((RLW'(rep_idx_reg) + RLW'(1)) == rlen_eff);
        stat.line_open    = line_open_reg;
        stat.out_free     = !m_valid_reg || m_tready;
    end

    // Window bytes: written at the fill position, shifted toward entry zero.
    always_ff @(posedge aclk) begin
        if (cmd.append) begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
                if (count_reg == CW'(i)) begin
                    win_reg[i] <= in_byte;
                end
            end
        end else if (cmd.shift) begin
            for (int i = 0; i < MAX_PATTERN - 1; i++) begin
                win_reg[i] <= win_reg[i + 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            line_open_reg <= 1'b0;
            rep_idx_reg   <= '0;
        end else begin
            if (cfg_clear || cmd.clear_win) begin
                count_reg <= '0;
            end else if (cmd.append) begin
                count_reg <= count_reg + CW'(1);
            end else if (cmd.shift) begin
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.append) begin
                line_open_reg <= 1'b1;
            end else if (cmd.close_line) begin
                line_open_reg <= 1'b0;
            end
            if (cmd.clear_win) begin
                rep_idx_reg <= '0;
            end else if (cmd.emit && (cmd.sel == SEL_REP)) begin
                rep_idx_reg <= rep_idx_reg + RIW'(1);
            end
        end
    end

    always_comb begin
        case (cmd.sel)
            SEL_WIN:   out_byte = win_reg[0];
            SEL_REP:   out_byte = rep_cfg[8*rep_idx_reg +: 8];
            SEL_NL:    out_byte = NEWLINE;
            SEL_EMPTY: out_byte = 8'h00;
            default:   out_byte = 8'h00;
        endcase
    end

    // Output register: holds a result until the receiver takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg           <= out_byte;
            m_last_reg           <= cmd.last;
            m_user_reg[TU_VALID] <= (cmd.sel != SEL_EMPTY);
            m_user_reg[TU_DONE]  <= cmd.done;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    // A result is never loaded over one the receiver has not yet taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_tready))
        else $error("output register overwritten");

    // Writing the pattern length discards the pending window.
    a_cfg_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_clear |=> (count_reg == '0))
        else $error("window not cleared by pattern length write");

    // The end-of-text marker always closes its request.
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_user_reg[TU_DONE]) |-> m_last_reg)
        else $error("text done without run last");

endmodule
